// ----- rtl/wsenc_pkg.sv -----
`timescale 1ns / 1ps

package wsenc_pkg;

  // Register reset value and length field constants.
  localparam logic [7:0]  WSENC_HDR_RESET   = 8'd129;
  localparam logic [31:0] WSENC_SHORT_MAX   = 32'd125;
  localparam logic [31:0] WSENC_MID_MAX     = 32'd65535;
  localparam logic [7:0]  WSENC_LEN_CODE_16 = 8'd254;
  localparam logic [7:0]  WSENC_LEN_CODE_64 = 8'd255;
  localparam int          WSENC_QDEPTH      = 2;

  // Input action codes.
  localparam logic WSENC_ACT_START   = 1'b0;
  localparam logic WSENC_ACT_PAYLOAD = 1'b1;

  // Sequence positions within a header for each length form.
  localparam logic [3:0] WSENC_SHORT_KEY0 = 4'd2;
  localparam logic [3:0] WSENC_SHORT_END  = 4'd5;
  localparam logic [3:0] WSENC_MID_KEY0   = 4'd4;
  localparam logic [3:0] WSENC_MID_END    = 4'd7;
  localparam logic [3:0] WSENC_LONG_LEN0  = 4'd6;
  localparam logic [3:0] WSENC_LONG_KEY0  = 4'd10;
  localparam logic [3:0] WSENC_LONG_END   = 4'd13;

  // Kind of work handed from the front to the back.
  typedef enum logic [2:0] {
    EK_DATA,
    EK_ERROR,
    EK_START_SHORT,
    EK_START_MID,
    EK_START_LONG
  } wsenc_kind_t;

  // One queued work entry.
  typedef struct packed {
    wsenc_kind_t kind;
    logic [31:0] len;
    logic [31:0] key;
    logic [7:0]  dbyte;
    logic        last;
  } wsenc_entry_t;

  // Back end sequencer states.
  typedef enum logic {
    BK_IDLE,
    BK_HDR
  } wsenc_bk_state_t;

  // Select key byte k, where byte zero sits in bits 31:24.
  function automatic logic [7:0] wsenc_key_byte(input logic [31:0] key, input logic [1:0] k);
    logic [7:0] b;
    case (k)
      2'd0: b = key[31:24];
      2'd1: b = key[23:16];
      2'd2: b = key[15:8];
      default: b = key[7:0];
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/wsenc_front.sv -----
`timescale 1ns / 1ps

module wsenc_front import wsenc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic         in_action,
  input  logic [31:0]  in_payload_length,
  input  logic [31:0]  in_mask_key,
  input  logic [7:0]   in_data_byte,
  input  logic         q_full,
  output logic         q_push,
  output wsenc_entry_t q_entry
);

  logic [31:0] rem_r, rem_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  kidx_r, kidx_nxt;
  logic        open_r, open_nxt;
  logic [31:0] rem_dec;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign rem_dec  = rem_r - 32'd1;

  // Classify the item and track the open frame.
  always_comb begin
    rem_nxt  = rem_r;
    key_nxt  = key_r;
    kidx_nxt = kidx_r;
    open_nxt = open_r;
    q_entry.kind  = EK_ERROR;
    q_entry.len   = in_payload_length;
    q_entry.key   = in_mask_key;
    q_entry.dbyte = 8'd0;
    q_entry.last  = 1'b0;
    if (in_action == WSENC_ACT_START) begin
      if (in_payload_length <= WSENC_SHORT_MAX) begin
        q_entry.kind = EK_START_SHORT;
      end else if (in_payload_length <= WSENC_MID_MAX) begin
        q_entry.kind = EK_START_MID;
      end else begin
        q_entry.kind = EK_START_LONG;
      end
      q_entry.last = (in_payload_length == 32'd0);
      if (q_push) begin
        rem_nxt  = in_payload_length;
        key_nxt  = in_mask_key;
        kidx_nxt = 2'd0;
        open_nxt = (in_payload_length != 32'd0);
      end
    end else if (open_r && (rem_r != 32'd0)) begin
      q_entry.kind  = EK_DATA;
      q_entry.dbyte = in_data_byte ^ wsenc_key_byte(key_r, kidx_r);
      q_entry.last  = (rem_dec == 32'd0);
      if (q_push) begin
        rem_nxt  = rem_dec;
        kidx_nxt = kidx_r + 2'd1;
        if (rem_dec == 32'd0) begin
          open_nxt = 1'b0;
        end
      end
    end
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= 32'd0;
      key_r  <= 32'd0;
      kidx_r <= 2'd0;
      open_r <= 1'b0;
    end else begin
      rem_r  <= rem_nxt;
      key_r  <= key_nxt;
      kidx_r <= kidx_nxt;
      open_r <= open_nxt;
    end
  end

endmodule

// ----- rtl/wsenc_queue.sv -----
`timescale 1ns / 1ps

module wsenc_queue import wsenc_pkg::*; #(
  parameter int DEPTH = WSENC_QDEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  wsenc_entry_t push_entry,
  output logic         full,
  input  logic         pop,
  output wsenc_entry_t pop_entry,
  output logic         not_empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  wsenc_entry_t slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign pop_entry = slot_r[rd_ptr_r];

  // Pointer and count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ----- rtl/wsenc_back.sv -----
`timescale 1ns / 1ps

module wsenc_back import wsenc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_valid,
  input  wsenc_entry_t q_entry,
  output logic         q_pop,
  input  logic [7:0]   first_hdr,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [7:0]   out_byte,
  output logic         out_last,
  output logic         out_error
);

  wsenc_bk_state_t state_r, state_nxt;
  wsenc_kind_t     kind_r, kind_nxt;
  logic [31:0]     len_r, len_nxt;
  logic [31:0]     key_r, key_nxt;
  logic            zlen_r, zlen_nxt;
  logic [3:0]      idx_r, idx_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_byte_r, out_byte_nxt;
  logic            out_last_r, out_last_nxt;
  logic            out_error_r, out_error_nxt;
  logic            out_free;
  logic [7:0]      seq_byte;
  logic [3:0]      end_idx;
  logic [3:0]      koff;
  logic [3:0]      loff;

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;
  assign out_error = out_error_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Header byte at the current sequence position.
  always_comb begin
    seq_byte = 8'd0;
    end_idx  = WSENC_SHORT_END;
    koff     = idx_r - WSENC_SHORT_KEY0;
    loff     = idx_r - WSENC_LONG_LEN0;
    case (kind_r)
      EK_START_MID: begin
        end_idx = WSENC_MID_END;
        koff    = idx_r - WSENC_MID_KEY0;
        if (idx_r == 4'd1) begin
          seq_byte = WSENC_LEN_CODE_16;
        end else if (idx_r == 4'd2) begin
          seq_byte = len_r[15:8];
        end else if (idx_r == 4'd3) begin
          seq_byte = len_r[7:0];
        end else begin
          seq_byte = wsenc_key_byte(key_r, koff[1:0]);
        end
      end
      EK_START_LONG: begin
        end_idx = WSENC_LONG_END;
        koff    = idx_r - WSENC_LONG_KEY0;
        if (idx_r == 4'd1) begin
          seq_byte = WSENC_LEN_CODE_64;
        end else if (idx_r < WSENC_LONG_LEN0) begin
          seq_byte = 8'd0;
        end else if (idx_r < WSENC_LONG_KEY0) begin
          seq_byte = wsenc_key_byte(len_r, loff[1:0]);
        end else begin
          seq_byte = wsenc_key_byte(key_r, koff[1:0]);
        end
      end
      default: begin
        if (idx_r == 4'd1) begin
          seq_byte = {1'b1, len_r[6:0]};
        end else begin
          seq_byte = wsenc_key_byte(key_r, koff[1:0]);
        end
      end
    endcase
  end

  // Sequencer: pops entries and emits one byte per free output slot.
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    len_nxt       = len_r;
    key_nxt       = key_r;
    zlen_nxt      = zlen_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_error_nxt = out_error_r;
    q_pop         = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (out_free) begin
          out_valid_nxt = 1'b0;
          if (q_valid) begin
            q_pop         = 1'b1;
            out_valid_nxt = 1'b1;
            case (q_entry.kind)
              EK_DATA: begin
                out_byte_nxt  = q_entry.dbyte;
                out_last_nxt  = q_entry.last;
                out_error_nxt = 1'b0;
              end
              EK_ERROR: begin
                out_byte_nxt  = 8'd0;
                out_last_nxt  = 1'b0;
                out_error_nxt = 1'b1;
              end
              default: begin
                out_byte_nxt  = first_hdr;
                out_last_nxt  = 1'b0;
                out_error_nxt = 1'b0;
                kind_nxt      = q_entry.kind;
                len_nxt       = q_entry.len;
                key_nxt       = q_entry.key;
                zlen_nxt      = q_entry.last;
                idx_nxt       = 4'd1;
                state_nxt     = BK_HDR;
              end
            endcase
          end
        end
      end
      BK_HDR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = seq_byte;
          out_last_nxt  = (idx_r == end_idx) && zlen_r;
          out_error_nxt = 1'b0;
          idx_nxt       = idx_r + 4'd1;
          if (idx_r == end_idx) begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    len_r       <= len_nxt;
    key_r       <= key_nxt;
    zlen_r      <= zlen_nxt;
    idx_r       <= idx_nxt;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
    out_error_r <= out_error_nxt;
  end

endmodule

// ----- rtl/websocket_masked_frame_encoder.sv -----
`timescale 1ns / 1ps

// Masked client websocket frame encoder. A start item (action 0) produces
// the frame header: the first header byte register, the length field (1,
// 3 or 9 bytes by payload length) and the four key bytes, so 6, 8 or 14
// output transactions. Each payload item (action 1) produces one masked
// byte; an unexpected payload byte produces one transaction with
// out_error set and is otherwise dropped. The output rate is one byte
// per cycle unless stalled, set by the back end sequencer that drives the
// output register. A queue of QDEPTH entries sits between the classifying
// front end and the sequencer, so input items are taken while a header is
// still going out, until that queue fills. The first header byte register
// is written through the cfg port, which is always ready; write it only
// while no frame bytes are pending.
module websocket_masked_frame_encoder import wsenc_pkg::*; #(
  parameter int QDEPTH = WSENC_QDEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [31:0] in_payload_length,
  input  logic [31:0] in_mask_key,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_error,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_first_header_byte
);

  logic [7:0]   first_hdr_r, first_hdr_nxt;
  logic         q_full;
  logic         q_push;
  logic         q_pop;
  logic         q_not_empty;
  wsenc_entry_t push_entry;
  wsenc_entry_t pop_entry;

  // Configuration register.
  assign cfg_ready     = 1'b1;
  assign first_hdr_nxt = (cfg_valid && cfg_ready) ? cfg_first_header_byte : first_hdr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_hdr_r <= WSENC_HDR_RESET;
    end else begin
      first_hdr_r <= first_hdr_nxt;
    end
  end

  wsenc_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_payload_length (in_payload_length),
    .in_mask_key       (in_mask_key),
    .in_data_byte      (in_data_byte),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_entry           (push_entry)
  );

  wsenc_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .not_empty  (q_not_empty)
  );

  wsenc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_entry   (pop_entry),
    .q_pop     (q_pop),
    .first_hdr (first_hdr_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .out_error (out_error)
  );

endmodule

// ----- bench/websocket_masked_frame_encoder_tb.sv -----
`timescale 1ns / 1ps

module websocket_masked_frame_encoder_tb import wsenc_pkg::*; ();

  // Mask flag that rides in the short length byte.
  localparam logic [7:0] MASK_FLAG = 8'h80;

  // One byte of the framed stream as the block should present it.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } stream_byte_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_action;
  logic [31:0] in_payload_length;
  logic [31:0] in_mask_key;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_error;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_first_header_byte;

  // Mirror of the encoder state and its header register.
  logic [7:0]  first_header_mirror;
  logic [31:0] payload_left;
  logic [31:0] frame_key;
  logic [1:0]  key_pos;
  logic        frame_active;

  stream_byte_t frame_bytes_expected[$];
  stream_byte_t head_byte;
  int mismatches = 0;
  int items_sent = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  websocket_masked_frame_encoder uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_action             (in_action),
    .in_payload_length     (in_payload_length),
    .in_mask_key           (in_mask_key),
    .in_data_byte          (in_data_byte),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_byte              (out_byte),
    .out_last              (out_last),
    .out_error             (out_error),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_first_header_byte (cfg_first_header_byte)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Key byte zero sits in the top byte of the key.
  function automatic logic [7:0] key_byte_at(input logic [31:0] key, input logic [1:0] pos);
    return key[8 * (3 - pos) +: 8];
  endfunction

  function automatic void push_byte(input logic [7:0] data, input logic last,
                                    input logic err);
    stream_byte_t b;
    b.data = data;
    b.last = last;
    b.err  = err;
    frame_bytes_expected.push_back(b);
  endfunction

  // Works out the bytes one accepted input transaction produces and updates the mirror.
  function automatic void predict_frame_bytes(input logic action, input logic [31:0] length,
                                              input logic [31:0] key, input logic [7:0] data);
    int i;
    if (action == WSENC_ACT_START) begin
      push_byte(first_header_mirror, 1'b0, 1'b0);
      if (length <= WSENC_SHORT_MAX) begin
        push_byte(MASK_FLAG | length[7:0], 1'b0, 1'b0);
      end else if (length <= WSENC_MID_MAX) begin
        push_byte(WSENC_LEN_CODE_16, 1'b0, 1'b0);
        push_byte(length[15:8], 1'b0, 1'b0);
        push_byte(length[7:0], 1'b0, 1'b0);
      end else begin
        // The upper half of the 64-bit length is always zero.
        push_byte(WSENC_LEN_CODE_64, 1'b0, 1'b0);
        for (i = 0; i < 4; i++) push_byte(8'h00, 1'b0, 1'b0);
        for (i = 0; i < 4; i++) push_byte(length[8 * (3 - i) +: 8], 1'b0, 1'b0);
      end
      for (i = 0; i < 4; i++) begin
        push_byte(key_byte_at(key, i[1:0]), (i == 3) && (length == 32'd0), 1'b0);
      end
      frame_key    = key;
      key_pos      = 2'd0;
      payload_left = length;
      frame_active = (length != 32'd0);
    end else if (!frame_active || payload_left == 32'd0) begin
      // A payload byte with nowhere to go is flagged and dropped.
      push_byte(8'h00, 1'b0, 1'b1);
    end else begin
      payload_left = payload_left - 32'd1;
      push_byte(data ^ key_byte_at(frame_key, key_pos), payload_left == 32'd0, 1'b0);
      key_pos = key_pos + 2'd1;
      if (payload_left == 32'd0) frame_active = 1'b0;
    end
  endfunction

  // Random backpressure on the output channel.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Compare each output transaction with the oldest expected byte.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (frame_bytes_expected.size() == 0) begin
        $display("%0t: output transaction with nothing expected: byte=%02h last=%0b error=%0b",
                 $time, out_byte, out_last, out_error);
        mismatches++;
      end else begin
        head_byte = frame_bytes_expected.pop_front();
        if (out_byte !== head_byte.data) begin
          $display("%0t: out_byte expected %02h actual %02h", $time, head_byte.data, out_byte);
          mismatches++;
        end
        if (out_last !== head_byte.last) begin
          $display("%0t: out_last expected %0b actual %0b", $time, head_byte.last, out_last);
          mismatches++;
        end
        if (out_error !== head_byte.err) begin
          $display("%0t: out_error expected %0b actual %0b", $time, head_byte.err, out_error);
          mismatches++;
        end
      end
    end
  end

  // Offers one input transaction, after random idle cycles, and waits until it is taken.
  task automatic send_item(input logic action, input logic [31:0] length,
                           input logic [31:0] key, input logic [7:0] data);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_action         <= action;
    in_payload_length <= length;
    in_mask_key       <= key;
    in_data_byte      <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_frame_bytes(action, length, key, data);
    items_sent++;
  endtask

  // Stops sending and waits until every expected byte has been seen.
  task automatic wait_for_results(input int limit);
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (frame_bytes_expected.size() != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
    if (frame_bytes_expected.size() != 0) begin
      $display("%0t: %0d expected bytes never came out", $time, frame_bytes_expected.size());
      mismatches++;
      frame_bytes_expected.delete();
    end
  endtask

  // Writes the first header byte register; only called with the block idle.
  task automatic write_first_header(input logic [7:0] value);
    cfg_valid             <= 1'b1;
    cfg_first_header_byte <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    first_header_mirror = value;
    cfg_valid <= 1'b0;
  endtask

  // Every length form, stray bytes, an empty frame and a restart mid-frame.
  task automatic test_frame_forms();
    send_item(WSENC_ACT_PAYLOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    send_item(WSENC_ACT_START, 32'd0, 32'hFFFF_FFFF, 8'h00);
    send_item(WSENC_ACT_PAYLOAD, 32'd0, 32'd0, 8'h00);
    send_item(WSENC_ACT_START, 32'd3, 32'h0102_0304, 8'hFF);
    send_item(WSENC_ACT_PAYLOAD, 32'd0, 32'd0, 8'h00);
    send_item(WSENC_ACT_PAYLOAD, 32'd0, 32'd0, 8'hFF);
    send_item(WSENC_ACT_PAYLOAD, 32'd0, 32'd0, 8'hA5);
    send_item(WSENC_ACT_PAYLOAD, 32'd0, 32'd0, 8'h5A);
    send_item(WSENC_ACT_START, 32'd125, 32'd0, 8'h00);
    send_item(WSENC_ACT_PAYLOAD, 32'd0, 32'd0, 8'h3C);
    send_item(WSENC_ACT_START, 32'd126, 32'hDEAD_BEEF, 8'h00);
    send_item(WSENC_ACT_PAYLOAD, 32'd0, 32'd0, 8'h11);
    // The open frame is abandoned by each new start.
    send_item(WSENC_ACT_START, 32'd65535, 32'h8000_0001, 8'h00);
    send_item(WSENC_ACT_PAYLOAD, 32'd0, 32'd0, 8'h11);
    send_item(WSENC_ACT_START, 32'd65536, 32'hC3A5_5A3C, 8'h00);
    repeat (5) send_item(WSENC_ACT_PAYLOAD, 32'd0, 32'd0, 8'($urandom_range(255)));
    send_item(WSENC_ACT_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    send_item(WSENC_ACT_PAYLOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    wait_for_results(20000);
  endtask

  // Header register at both extremes and one ordinary value.
  task automatic test_header_register();
    write_first_header(8'h00);
    send_item(WSENC_ACT_START, 32'd1, 32'h5555_AAAA, 8'h00);
    send_item(WSENC_ACT_PAYLOAD, 32'd0, 32'd0, 8'h0F);
    wait_for_results(20000);
    write_first_header(8'hFF);
    send_item(WSENC_ACT_START, 32'd0, 32'hAAAA_5555, 8'h00);
    wait_for_results(20000);
    write_first_header(8'h82);
    send_item(WSENC_ACT_START, 32'd200, 32'h1234_5678, 8'h00);
    send_item(WSENC_ACT_PAYLOAD, 32'd0, 32'd0, 8'hC0);
    wait_for_results(20000);
  endtask

  // Mostly well-formed frames with random content, plus stray and overlong bytes.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
    int first_item;
    int kind;
    int pick;
    int n_payload;
    logic [31:0] length;
    wait_for_results(20000);
    write_first_header(8'($urandom_range(255)));
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    first_item = items_sent;
    while (items_sent - first_item < count) begin
      kind = $urandom_range(99);
      if (kind < 8) begin
        send_item(WSENC_ACT_PAYLOAD, $urandom, $urandom, 8'($urandom_range(255)));
      end else begin
        if (kind < 18) length = 32'd0;
        else if (kind < 70) length = $urandom_range(12, 1);
        else if (kind < 82) length = $urandom_range(131, 120);
        else if (kind < 92) length = $urandom_range(65540, 65530);
        else length = $urandom;
        if (length <= 32'd40) begin
          pick = $urandom_range(99);
          if (pick < 70) n_payload = length;
          else if (pick < 85) n_payload = length + $urandom_range(2, 1);
          else n_payload = $urandom_range(length, 0);
        end else if (length <= 32'd131 && $urandom_range(99) < 15) begin
          n_payload = length;
        end else begin
          n_payload = $urandom_range(5, 0);
        end
        send_item(WSENC_ACT_START, length, $urandom, 8'($urandom_range(255)));
        repeat (n_payload) begin
          send_item(WSENC_ACT_PAYLOAD, $urandom, $urandom, 8'($urandom_range(255)));
        end
        // Now and then let the output run completely dry.
        if ($urandom_range(99) < 8) wait_for_results(20000);
      end
    end
  endtask

  initial begin
    rst_n                 = 1'b0;
    in_valid              = 1'b0;
    in_action             = WSENC_ACT_START;
    in_payload_length     = 32'd0;
    in_mask_key           = 32'd0;
    in_data_byte          = 8'd0;
    out_stall             = 1'b0;
    cfg_valid             = 1'b0;
    cfg_first_header_byte = 8'd0;
    first_header_mirror   = WSENC_HDR_RESET;
    payload_left          = 32'd0;
    frame_key             = 32'd0;
    key_pos               = 2'd0;
    frame_active          = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_frame_forms();
    test_header_register();
    test_random_traffic(0, 0, 55);
    test_random_traffic(78, 0, 55);
    test_random_traffic(0, 78, 55);
    test_random_traffic(12, 12, 55);

    wait_for_results(20000);
    repeat (20) @(posedge clk);
    if (frame_bytes_expected.size() != 0) begin
      $display("%0t: %0d expected bytes left over", $time, frame_bytes_expected.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/wsenc_pkg.sv
rtl/wsenc_front.sv
rtl/wsenc_queue.sv
rtl/wsenc_back.sv
rtl/websocket_masked_frame_encoder.sv
bench/websocket_masked_frame_encoder_tb.sv
